// ===== rtl/set_assoc_writeback_cache_lru_core_assert.svh =====
// Assertion macros shared by the cache core RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SET_ASSOC_WRITEBACK_CACHE_LRU_CORE_ASSERT_SVH
`define SET_ASSOC_WRITEBACK_CACHE_LRU_CORE_ASSERT_SVH

// Same-cycle implication, gated off while reset is applied.
`define SAWC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sawc: same-cycle check failed");

// Next-cycle implication, gated off while reset is applied.
`define SAWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sawc: next-cycle check failed");

`endif

// ===== rtl/sawc_pkg.sv =====
// Shared types, constants and helper functions of the cache core.
// Depends on nothing; imported by the front end, the back end and the top level.
package sawc_pkg;

    localparam int ADDR_W     = 32;
    localparam int STAMP_W    = 32;
    localparam int EV_TAG_W   = 28;
    localparam int COST_W     = 16;
    localparam int WAY_OUT_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    localparam logic [3:0]        WAY_COUNT_RESET  = 4'd8;
    localparam logic [3:0]        INDEX_BITS_RESET = 4'd6;
    localparam logic [COST_W-1:0] CLEAN_COST_RESET = 16'd81;
    localparam logic [COST_W-1:0] DIRTY_COST_RESET = 16'd161;
    localparam logic [COST_W-1:0] HIT_COST         = 16'd1;

    typedef enum logic [1:0] {
        REG_WAY_COUNT  = 2'd0,
        REG_INDEX_BITS = 2'd1,
        REG_CLEAN_COST = 2'd2,
        REG_DIRTY_COST = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [3:0]        way_count;
        logic [3:0]        index_bits;
        logic [COST_W-1:0] clean_miss_cost;
        logic [COST_W-1:0] dirty_miss_cost;
    } cfg_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic                 evicted_valid;
        logic                 evicted_dirty;
        logic [EV_TAG_W-1:0]  evicted_tag;
        logic [COST_W-1:0]    cost_cycles;
        logic [STAMP_W-1:0]   access_number;
    } res_t;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_LOOKUP = 3'd2,
        ST_SCAN   = 3'd3,
        ST_WRITE  = 3'd4
    } back_state_t;

    // Largest b with 2**b <= n, for n >= 1.
    function automatic int floor_log2(input int n);
        int b;
        b = 0;
        for (int i = 0; i < 30; i++)
        begin
            if ((2 << i) <= n)
            begin
                b = i + 1;
            end
        end
        return b;
    endfunction

endpackage

// ===== rtl/sawc_fifo.sv =====
// Small register-based FIFO used for the request queue and the result queue.
// Depends on the assertion macro header only.
`include "set_assoc_writeback_cache_lru_core_assert.svh"

module sawc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    `SAWC_ASSERT_IMPLIES(a_fifo_count_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `SAWC_ASSERT_NEXT(a_fifo_push_fills, clk, rst_n, do_push, !empty)
    `SAWC_ASSERT_NEXT(a_fifo_pop_frees, clk, rst_n, do_pop && !do_push, !full)

endmodule

// ===== rtl/sawc_front.sv =====
// Front end: configuration registers, request intake and address split.
// Depends on sawc_pkg.
module sawc_front
    import sawc_pkg::*;
#(
    parameter int MAX_SETS   = 1024,
    parameter int LINE_BYTES = 16,
    localparam int OFF_BITS  = floor_log2(LINE_BYTES),
    localparam int TAG_W     = ADDR_W - OFF_BITS,
    localparam int MAX_IB    = floor_log2(MAX_SETS),
    localparam int SET_W     = (MAX_IB > 0) ? MAX_IB : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  push,
    input  logic                  op,
    input  logic [ADDR_W-1:0]     address,
    output logic                  full,
    input  logic                  clearing,
    input  logic                  cmd_full,
    output logic                  cmd_push,
    output logic                  cmd_op,
    output logic [SET_W-1:0]      cmd_set,
    output logic [TAG_W-1:0]      cmd_tag,
    output cfg_t                  cfg
);

    cfg_t             cfg_reg, cfg_next;
    reg_idx_t         reg_idx;
    logic [3:0]       ib_eff;
    logic [SET_W-1:0] set_mask;
    logic [TAG_W-1:0] line_addr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_WAY_COUNT:  cfg_next.way_count       = pwdata[3:0];
                REG_INDEX_BITS: cfg_next.index_bits      = pwdata[3:0];
                REG_CLEAN_COST: cfg_next.clean_miss_cost = pwdata[COST_W-1:0];
                REG_DIRTY_COST: cfg_next.dirty_miss_cost = pwdata[COST_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WAY_COUNT:  prdata = CFG_DATA_W'(cfg_reg.way_count);
            REG_INDEX_BITS: prdata = CFG_DATA_W'(cfg_reg.index_bits);
            REG_CLEAN_COST: prdata = CFG_DATA_W'(cfg_reg.clean_miss_cost);
            REG_DIRTY_COST: prdata = CFG_DATA_W'(cfg_reg.dirty_miss_cost);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.way_count       <= WAY_COUNT_RESET;
            cfg_reg.index_bits      <= INDEX_BITS_RESET;
            cfg_reg.clean_miss_cost <= CLEAN_COST_RESET;
            cfg_reg.dirty_miss_cost <= DIRTY_COST_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Saturate the index width to what the set store holds.
    assign ib_eff    = (cfg_reg.index_bits > 4'(MAX_IB)) ? 4'(MAX_IB) : cfg_reg.index_bits;
    assign set_mask  = ~({SET_W{1'b1}} << ib_eff);
    assign line_addr = address[ADDR_W-1:OFF_BITS];

    // Hold off requests while the line-state store is being cleared.
    assign full     = cmd_full || clearing;
    assign cmd_push = push && !full;
    assign cmd_op   = op;
    assign cmd_set  = line_addr[SET_W-1:0] & set_mask;
    assign cmd_tag  = line_addr >> ib_eff;

endmodule

// ===== rtl/sawc_back.sv =====
// Back end: line-state memory, hit check, victim choice and state update.
// Depends on sawc_pkg and the assertion macro header.
`include "set_assoc_writeback_cache_lru_core_assert.svh"

module sawc_back
    import sawc_pkg::*;
#(
    parameter int MAX_WAYS   = 8,
    parameter int MAX_SETS   = 1024,
    parameter int LINE_BYTES = 16,
    localparam int OFF_BITS  = floor_log2(LINE_BYTES),
    localparam int TAG_W     = ADDR_W - OFF_BITS,
    localparam int MAX_IB    = floor_log2(MAX_SETS),
    localparam int SET_W     = (MAX_IB > 0) ? MAX_IB : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             cmd_empty,
    input  logic             cmd_op,
    input  logic [SET_W-1:0] cmd_set,
    input  logic [TAG_W-1:0] cmd_tag,
    output logic             cmd_pop,
    input  logic             res_full,
    output logic             res_push,
    output res_t             res,
    output logic             clearing
);

    localparam int SET_DEPTH = 1 << MAX_IB;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WC_W      = $clog2(MAX_WAYS + 1);
    localparam int ENT_W     = TAG_W + STAMP_W + 2;
    localparam int ROW_W     = MAX_WAYS * ENT_W;

    back_state_t        state_reg, state_next;
    logic [SET_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [STAMP_W-1:0] stamp_cnt_reg, stamp_cnt_next;
    logic               op_reg, op_next;
    logic [SET_W-1:0]   set_reg, set_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic               hit_reg, hit_next;
    logic [WAY_W-1:0]   chosen_reg, chosen_next;
    logic [WAY_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [STAMP_W-1:0] oldest_reg, oldest_next;
    logic [ROW_W-1:0]   row_reg;

    logic [ROW_W-1:0]   row_mem [SET_DEPTH];
    logic               mem_re, mem_we;
    logic [SET_W-1:0]   mem_waddr;
    logic [ROW_W-1:0]   mem_wdata;

    logic               e_valid [MAX_WAYS];
    logic               e_dirty [MAX_WAYS];
    logic [STAMP_W-1:0] e_stamp [MAX_WAYS];
    logic [TAG_W-1:0]   e_tag   [MAX_WAYS];

    logic [4:0]         wc_raw;
    logic [WC_W-1:0]    ways_eff;
    logic [MAX_WAYS-1:0] match, empty_way;
    logic [WAY_W-1:0]   hit_way, inv_way;
    logic               ev_valid, ev_dirty;
    logic [TAG_W-1:0]   ev_tag;
    logic [ENT_W-1:0]   new_ent;
    logic [ROW_W-1:0]   wr_row;

    assign clearing = (state_reg == ST_CLEAR);

    // Clamp the way count to 1..MAX_WAYS.
    assign wc_raw = {1'b0, cfg.way_count};
    always_comb
    begin
        if (wc_raw == '0)
        begin
            ways_eff = WC_W'(1);
        end
        else if (wc_raw > 5'(MAX_WAYS))
        begin
            ways_eff = WC_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WC_W'(wc_raw);
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_WAYS; k++)
        begin
            {e_valid[k], e_dirty[k], e_stamp[k], e_tag[k]} = row_reg[k*ENT_W +: ENT_W];
        end
    end

    // Tag compare across the ways in use; highest match wins, lowest empty way wins.
    always_comb
    begin
        hit_way = '0;
        inv_way = '0;
        for (int k = 0; k < MAX_WAYS; k++)
        begin
            match[k]     = (WC_W'(k) < ways_eff) && e_valid[k] && (e_tag[k] == tag_reg);
            empty_way[k] = (WC_W'(k) < ways_eff) && !e_valid[k];
        end
        for (int k = 0; k < MAX_WAYS; k++)
        begin
            if (match[k])
            begin
                hit_way = WAY_W'(k);
            end
        end
        for (int k = MAX_WAYS - 1; k >= 0; k--)
        begin
            if (empty_way[k])
            begin
                inv_way = WAY_W'(k);
            end
        end
    end

    // Build the updated row and the result for the chosen way.
    always_comb
    begin
        ev_valid = !hit_reg && e_valid[chosen_reg];
        ev_dirty = ev_valid && e_dirty[chosen_reg];
        ev_tag   = ev_valid ? e_tag[chosen_reg] : '0;
        if (hit_reg)
        begin
            new_ent = {1'b1, e_dirty[chosen_reg] | op_reg, stamp_cnt_reg, e_tag[chosen_reg]};
        end
        else
        begin
            new_ent = {1'b1, op_reg, stamp_cnt_reg, tag_reg};
        end
        for (int k = 0; k < MAX_WAYS; k++)
        begin
            wr_row[k*ENT_W +: ENT_W] = (WAY_W'(k) == chosen_reg) ? new_ent
                                                                 : row_reg[k*ENT_W +: ENT_W];
        end
        res.hit           = hit_reg;
        res.way           = WAY_OUT_W'(chosen_reg);
        res.evicted_valid = ev_valid;
        res.evicted_dirty = ev_dirty;
        res.evicted_tag   = EV_TAG_W'(ev_tag);
        res.cost_cycles   = hit_reg ? HIT_COST
                          : (ev_dirty ? cfg.dirty_miss_cost : cfg.clean_miss_cost);
        res.access_number = stamp_cnt_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        stamp_cnt_next = stamp_cnt_reg;
        op_next        = op_reg;
        set_next       = set_reg;
        tag_next       = tag_reg;
        hit_next       = hit_reg;
        chosen_next    = chosen_reg;
        scan_idx_next  = scan_idx_reg;
        oldest_next    = oldest_reg;
        cmd_pop        = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = set_reg;
        mem_wdata      = wr_row;
        res_push       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
                if (clr_idx_reg == SET_W'(SET_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    mem_re     = 1'b1;
                    op_next    = cmd_op;
                    set_next   = cmd_set;
                    tag_next   = cmd_tag;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (|match)
                begin
                    hit_next    = 1'b1;
                    chosen_next = hit_way;
                    state_next  = ST_WRITE;
                end
                else if (|empty_way)
                begin
                    hit_next    = 1'b0;
                    chosen_next = inv_way;
                    state_next  = ST_WRITE;
                end
                else if (ways_eff == WC_W'(1))
                begin
                    hit_next    = 1'b0;
                    chosen_next = '0;
                    state_next  = ST_WRITE;
                end
                else
                begin
                    hit_next      = 1'b0;
                    chosen_next   = '0;
                    oldest_next   = e_stamp[0];
                    scan_idx_next = WAY_W'(1);
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (e_stamp[scan_idx_reg] < oldest_reg)
                begin
                    oldest_next = e_stamp[scan_idx_reg];
                    chosen_next = scan_idx_reg;
                end
                if (WC_W'(scan_idx_reg) == ways_eff - WC_W'(1))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_WRITE:
            begin
                if (!res_full)
                begin
                    mem_we         = 1'b1;
                    res_push       = 1'b1;
                    stamp_cnt_next = stamp_cnt_reg + 32'd1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            stamp_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            stamp_cnt_reg <= stamp_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        set_reg      <= set_next;
        tag_reg      <= tag_next;
        hit_reg      <= hit_next;
        chosen_reg   <= chosen_next;
        scan_idx_reg <= scan_idx_next;
        oldest_reg   <= oldest_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            row_reg <= row_mem[cmd_set];
        end
    end

    `SAWC_ASSERT_IMPLIES(a_hit_no_evict, clk, rst_n, res_push && res.hit, !res.evicted_valid && !res.evicted_dirty && (res.evicted_tag == '0))
    `SAWC_ASSERT_NEXT(a_stamp_advance, clk, rst_n, res_push, stamp_cnt_reg == $past(stamp_cnt_reg) + 32'd1)
    `SAWC_ASSERT_IMPLIES(a_no_pop_clear, clk, rst_n, clearing, !cmd_pop && !res_push)

endmodule

// ===== rtl/set_assoc_writeback_cache_lru_core.sv =====
// Top level of the write-back, write-allocate set-associative cache tag engine.
// Depends on sawc_pkg, sawc_front, sawc_fifo and sawc_back.
//
// Each request is a read or write to a 32-bit byte address; for each one the
// core returns exactly one result: hit flag, way used, the state of the line
// it evicted (valid, dirty, tag), the charged cost and the access number that
// serves as the line's last-use stamp. Replacement takes the lowest empty way,
// else the way with the smallest stamp. Requests enter through a queue-style
// push/full port, results leave through an empty/pop port. The front end
// splits the address and drops the request into a two-entry request queue; the
// back end owns one line-state memory row per set (all ways side by side) and
// does a read-modify-write on that row for every request, so it handles one
// request at a time. Each request passes through the registered row read, the
// lookup and the row write, which waits while the result queue is full. A miss
// into a full set with more than one way in use (ways in use: way_count clamped
// to 1..MAX_WAYS) adds a stamp scan between lookup and write, where one stamp is
// compared per cycle to find the oldest line. A two-entry result queue lets the
// back end move on while a result waits to be popped. After reset a clearing
// pass writes every row once (2**floor(log2(MAX_SETS)) rows, 1024 by default);
// full stays high until it ends, while register writes are taken as usual.
// Configuration goes through an APB-style port with registers at byte addresses
// 0 (way_count), 4 (index_bits), 8 (clean_miss_cost) and 12 (dirty_miss_cost);
// change it only while no request is in flight.
module set_assoc_writeback_cache_lru_core
    import sawc_pkg::*;
#(
    parameter int MAX_WAYS   = 8,
    parameter int MAX_SETS   = 1024,
    parameter int LINE_BYTES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  push,
    output logic                  full,
    input  logic                  op,
    input  logic [ADDR_W-1:0]     address,
    output logic                  empty,
    input  logic                  pop,
    output logic                  hit,
    output logic [WAY_OUT_W-1:0]  way,
    output logic                  evicted_valid,
    output logic                  evicted_dirty,
    output logic [EV_TAG_W-1:0]   evicted_tag,
    output logic [COST_W-1:0]     cost_cycles,
    output logic [STAMP_W-1:0]    access_number
);

    localparam int OFF_BITS = floor_log2(LINE_BYTES);
    localparam int TAG_W    = ADDR_W - OFF_BITS;
    localparam int MAX_IB   = floor_log2(MAX_SETS);
    localparam int SET_W    = (MAX_IB > 0) ? MAX_IB : 1;
    localparam int CMD_W    = 1 + SET_W + TAG_W;
    localparam int RES_W    = $bits(res_t);

    cfg_t             cfg;
    logic             clearing;

    // Request path: front end into the request queue.
    logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
    logic             fe_op, be_op;
    logic [SET_W-1:0] fe_set, be_set;
    logic [TAG_W-1:0] fe_tag, be_tag;
    logic [CMD_W-1:0] cmd_wdata, cmd_rdata;

    // Result path: back end into the result queue.
    logic             res_push, res_full;
    res_t             be_res, res_head;
    logic [RES_W-1:0] res_rdata;

    sawc_front #(
        .MAX_SETS   (MAX_SETS),
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .push     (push),
        .op       (op),
        .address  (address),
        .full     (full),
        .clearing (clearing),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd_op   (fe_op),
        .cmd_set  (fe_set),
        .cmd_tag  (fe_tag),
        .cfg      (cfg)
    );

    // Pack the classified request for the queue; unpack it on the far side.
    assign cmd_wdata = {fe_op, fe_set, fe_tag};
    assign {be_op, be_set, be_tag} = cmd_rdata;

    sawc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    sawc_back #(
        .MAX_WAYS   (MAX_WAYS),
        .MAX_SETS   (MAX_SETS),
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_empty (cmd_empty),
        .cmd_op    (be_op),
        .cmd_set   (be_set),
        .cmd_tag   (be_tag),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (be_res),
        .clearing  (clearing)
    );

    sawc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (be_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    // Drive the result ports from the oldest waiting result.
    assign res_head      = res_rdata;
    assign hit           = res_head.hit;
    assign way           = res_head.way;
    assign evicted_valid = res_head.evicted_valid;
    assign evicted_dirty = res_head.evicted_dirty;
    assign evicted_tag   = res_head.evicted_tag;
    assign cost_cycles   = res_head.cost_cycles;
    assign access_number = res_head.access_number;

endmodule
